// File: src/xte_pkg.sv
// xte_pkg: shared types, character constants and escape tables for the xml text escaper
// no dependencies; used by the interfaces, xte_expander and xml_text_escaper_unit
package xte_pkg;

  // running escaped-length counter width
  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned LEN_WIDTH   = 16;
  localparam logic [LEN_WIDTH-1:0] LEN_MAX = '1;

  // longest escape sequence is "&amp;", five bytes
  localparam int unsigned IDX_WIDTH = 3;

  // source characters that trigger an escape
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_DQUOT = 8'h22;

  // characters used in the escape sequences
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_L     = 8'h6c;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_M     = 8'h6d;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_TWO   = 8'h32;

  typedef enum logic [2:0] {
    ESC_NONE,
    ESC_LT,
    ESC_GT,
    ESC_AMP,
    ESC_QUOT,
    ESC_TERM
  } esc_kind_e;

  // one accepted input byte after classification
  typedef struct packed {
    esc_kind_e            kind;
    logic [7:0]           raw;
    logic [LEN_WIDTH-1:0] len;
  } item_t;

  // one output transaction
  typedef struct packed {
    logic [7:0]           out_byte;
    logic                 run_end;
    logic                 string_end;
    logic [LEN_WIDTH-1:0] string_length;
  } result_t;

  // classify a source byte
  function automatic esc_kind_e esc_classify(input logic [7:0] b, input logic attr);
    esc_kind_e k;
    k = ESC_NONE;
    if (b == CH_NUL) begin
      k = ESC_TERM;
    end else if (b == CH_LT) begin
      k = ESC_LT;
    end else if (b == CH_GT) begin
      k = ESC_GT;
    end else if (b == CH_AMP) begin
      k = ESC_AMP;
    end else if (b == CH_DQUOT && attr) begin
      k = ESC_QUOT;
    end
    return k;
  endfunction

  // number of output bytes produced for a kind
  function automatic logic [IDX_WIDTH-1:0] esc_len(input esc_kind_e k);
    logic [IDX_WIDTH-1:0] n;
    case (k)
      ESC_LT:   n = 3'd4;
      ESC_GT:   n = 3'd4;
      ESC_AMP:  n = 3'd5;
      ESC_QUOT: n = 3'd3;
      default:  n = 3'd1;
    endcase
    return n;
  endfunction

  // byte at position idx of the escaped form
  function automatic logic [7:0] esc_char(input esc_kind_e k, input logic [IDX_WIDTH-1:0] idx,
                                          input logic [7:0] raw);
    logic [7:0] c;
    case (k)
      ESC_LT: begin
        case (idx)
          3'd0:    c = CH_AMP;
          3'd1:    c = CH_L;
          3'd2:    c = CH_T;
          default: c = CH_SEMI;
        endcase
      end
      ESC_GT: begin
        case (idx)
          3'd0:    c = CH_AMP;
          3'd1:    c = CH_G;
          3'd2:    c = CH_T;
          default: c = CH_SEMI;
        endcase
      end
      ESC_AMP: begin
        case (idx)
          3'd0:    c = CH_AMP;
          3'd1:    c = CH_A;
          3'd2:    c = CH_M;
          3'd3:    c = CH_P;
          default: c = CH_SEMI;
        endcase
      end
      ESC_QUOT: begin
        case (idx)
          3'd0:    c = CH_PCT;
          default: c = CH_TWO;
        endcase
      end
      ESC_TERM: c = CH_NUL;
      default:  c = raw;
    endcase
    return c;
  endfunction

endpackage

// File: src/xte_if.sv
// xte_in_if / xte_out_if: valid/ready channels for source bytes and escaped results
// depends on xte_pkg for the field widths
interface xte_in_if
  import xte_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface xte_out_if
  import xte_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [7:0]           out_byte;
  logic                 run_end;
  logic                 string_end;
  logic [LEN_WIDTH-1:0] string_length;

  modport source (output valid, output out_byte, output run_end, output string_end,
                  output string_length, input ready);
  modport sink   (input valid, input out_byte, input run_end, input string_end,
                  input string_length, output ready);
endinterface

// File: src/xte_expander.sv
// xte_expander: holds one classified item and issues its escaped bytes into a result register
// depends on xte_pkg
module xte_expander
  import xte_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    item_valid_i,
  input  item_t   item_i,
  output logic    item_ready_o,
  output logic    res_valid_o,
  output result_t res_o,
  input  logic    res_ready_i
);

  logic                 s_valid_q;
  item_t                s_item_q;
  logic [IDX_WIDTH-1:0] s_idx_q;
  logic                 r_valid_q;
  result_t              r_q;
  result_t              r_d;
  logic                 r_load;
  logic                 s_last;
  logic                 item_take;
  logic                 is_term;

  // result register takes a byte when empty or being drained
  assign r_load       = s_valid_q && (!r_valid_q || res_ready_i);
  assign s_last       = (s_idx_q == esc_len(s_item_q.kind) - 3'd1);
  assign item_ready_o = !s_valid_q || (r_load && s_last);
  assign item_take    = item_valid_i && item_ready_o;
  assign is_term      = (s_item_q.kind == ESC_TERM);

  // next result from the held item
  always_comb begin
    r_d.out_byte      = esc_char(s_item_q.kind, s_idx_q, s_item_q.raw);
    r_d.run_end       = s_last;
    r_d.string_end    = is_term;
    r_d.string_length = is_term ? s_item_q.len : '0;
  end

  // item stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
      s_idx_q   <= '0;
    end else if (item_take) begin
      s_valid_q <= 1'b1;
      s_idx_q   <= '0;
    end else if (r_load && s_last) begin
      s_valid_q <= 1'b0;
    end else if (r_load) begin
      s_idx_q <= s_idx_q + 3'd1;
    end
  end

  // item payload
  always_ff @(posedge clk_i) begin
    if (item_take) begin
      s_item_q <= item_i;
    end
  end

  // result stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
    end else if (r_load) begin
      r_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      r_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (r_load) begin
      r_q <= r_d;
    end
  end

  assign res_valid_o = r_valid_q;
  assign res_o       = r_q;

endmodule

// File: src/xml_text_escaper_unit.sv
// xml_text_escaper_unit: byte-stream xml text escaper, top level
// depends on xte_pkg, xte_in_if / xte_out_if and xte_expander
//
// Usage: source text bytes arrive on in_i, one byte per transaction; escaped bytes leave on
// out_o, one byte per transaction. '<', '>' and '&' become "&lt;", "&gt;" and "&amp;";
// with attribute mode set (cfg_we_i / cfg_wdata_i) a double quote becomes "%22". A zero
// byte ends the string and yields one zero byte with string_end set and string_length
// carrying the escaped length (saturating); the running count then restarts at zero.
// An accepted item is first registered in the item stage; its first output byte is then
// registered in the result register, from which the receiver takes it.
// Throughput: one output byte per cycle while the receiver does not stall, set by the single
// item stage that issues one byte per cycle into the result register; an item produces 1
// output byte for plain bytes and terminators and 3 to 5 for escapes.
// A new byte is accepted in the cycle the previous item issues its last byte.
// Reset clears the count, attribute mode and both stages; no output is valid after reset.
// When the receiver stalls, the result register holds its transaction, the item stage
// holds its position, and in_i.ready drops once the item stage holds an item.
module xml_text_escaper_unit
  import xte_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  xte_in_if.sink     in_i,
  xte_out_if.source  out_o,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i
);

  logic                   attr_q;
  logic [COUNT_WIDTH-1:0] count_q;
  logic [COUNT_WIDTH-1:0] count_d;
  logic [COUNT_WIDTH:0]   count_sum;
  logic                   in_take;
  esc_kind_e              in_kind;
  item_t                  item;
  logic                   item_ready;
  logic                   res_valid;
  result_t                res;

  assign in_take = in_i.valid && item_ready;
  assign in_kind = esc_classify(in_i.in_byte, attr_q);

  // saturating length counter
  assign count_sum = {1'b0, count_q} + (COUNT_WIDTH+1)'(esc_len(in_kind));
  always_comb begin
    if (in_kind == ESC_TERM) begin
      count_d = '0;
    end else if (count_sum[COUNT_WIDTH]) begin
      count_d = '1;
    end else begin
      count_d = count_sum[COUNT_WIDTH-1:0];
    end
  end

  // classified item with length snapshot
  always_comb begin
    item.kind = in_kind;
    item.raw  = in_i.in_byte;
    item.len  = (32'(count_q) > 32'(LEN_MAX)) ? LEN_MAX : LEN_WIDTH'(count_q);
  end

  // count and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      attr_q  <= 1'b0;
    end else begin
      if (in_take) begin
        count_q <= count_d;
      end
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
    end
  end

  xte_expander u_expander (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_i.valid),
    .item_i       (item),
    .item_ready_o (item_ready),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_ready_i  (out_o.ready)
  );

  assign in_i.ready          = item_ready;
  assign out_o.valid         = res_valid;
  assign out_o.out_byte      = res.out_byte;
  assign out_o.run_end       = res.run_end;
  assign out_o.string_end    = res.string_end;
  assign out_o.string_length = res.string_length;

  // terminator is always a single, final, zero byte
  a_term_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.string_end |-> out_o.run_end && (out_o.out_byte == CH_NUL))
    else $error("terminator transaction malformed");

  // length only reported on the terminator
  a_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.string_end |-> (out_o.string_length == '0))
    else $error("length on non-terminator transaction");

  // count restarts after a terminator is taken
  a_count_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && (in_i.in_byte == CH_NUL) |=> (count_q == '0))
    else $error("count not cleared after terminator");

  // count never decreases except at a terminator
  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && (in_i.in_byte != CH_NUL) |=> (count_q >= $past(count_q)))
    else $error("count decreased without terminator");

endmodule
